FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ATRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ATRB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ATRB_ASSERT(lbl, prop, msg)
`define ATRB_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/atrb_pkg.sv
// ----------------------------------------------------------------------------
// atrb_pkg
// Operation codes and result type of the tagged result buffer ALU.
// ----------------------------------------------------------------------------
package atrb_pkg;

  localparam int unsigned KindBits  = 4;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned ShamtBits = 5;

  typedef enum logic [KindBits-1:0] {
    KIND_ADD     = 4'd0,
    KIND_SUB     = 4'd1,
    KIND_XOR     = 4'd2,
    KIND_OR      = 4'd3,
    KIND_AND     = 4'd4,
    KIND_SLL     = 4'd5,
    KIND_SRL     = 4'd6,
    KIND_SRA     = 4'd7,
    KIND_SLT     = 4'd8,
    KIND_SLTU    = 4'd9,
    KIND_LUI     = 4'd10,
    KIND_AUIPC   = 4'd11,
    KIND_MEMORY  = 4'd12,
    KIND_CONTROL = 4'd13
  } kind_e;

  typedef struct packed {
    logic [DataBits-1:0] value;
    logic                is_address;
    logic                is_control;
  } alu_res_t;

endpackage

FILE: design/atrb_alu.sv
// ----------------------------------------------------------------------------
// atrb_alu
// Combinational integer ALU with memory and control kind flags.
// ----------------------------------------------------------------------------
module atrb_alu import atrb_pkg::*; (
  input  logic [KindBits-1:0] kind_i,
  input  logic [DataBits-1:0] operand_a_i,
  input  logic [DataBits-1:0] operand_b_i,
  output alu_res_t            res_o
);

  logic [ShamtBits-1:0] shamt;
  logic [DataBits-1:0]  value;

  assign shamt = operand_b_i[ShamtBits-1:0];

  always_comb begin
    case (kind_i)
      KIND_ADD, KIND_AUIPC, KIND_MEMORY, KIND_CONTROL: value = operand_a_i + operand_b_i;
      KIND_SUB:  value = operand_a_i - operand_b_i;
      KIND_XOR:  value = operand_a_i ^ operand_b_i;
      KIND_OR:   value = operand_a_i | operand_b_i;
      KIND_AND:  value = operand_a_i & operand_b_i;
      KIND_SLL:  value = operand_a_i << shamt;
      KIND_SRL:  value = operand_a_i >> shamt;
      KIND_SRA:  value = DataBits'($signed(operand_a_i) >>> shamt);
      KIND_SLT:  value = DataBits'($signed(operand_a_i) < $signed(operand_b_i));
      KIND_SLTU: value = DataBits'(operand_a_i < operand_b_i);
      KIND_LUI:  value = operand_b_i;
      default:   value = '0;
    endcase
  end

  assign res_o.value      = value;
  assign res_o.is_address = (kind_i == KIND_MEMORY);
  assign res_o.is_control = (kind_i == KIND_CONTROL);

endmodule

FILE: design/alu_with_tagged_result_buffer.sv
// ----------------------------------------------------------------------------
// alu_with_tagged_result_buffer
// Integer ALU whose results are held in a small buffer keyed by reorder tag.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the output stalls, returning one word per
// word taken: it is captured in an input register, then the ALU, the parallel
// scan of the BUFFER_DEPTH entries (free slot, oldest tag, squash and retire
// matches) and the buffer update all happen as the word leaves the input
// register, which also loads the result register. Oldest, empty and full
// report the buffer as it stood before that word's update. A result is
// dropped with result_stored low if the buffer is full or the issue is squashed.
`include "assert_macros.svh"

module alu_with_tagged_result_buffer import atrb_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 4,
  parameter int unsigned TAG_BITS     = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                issue_valid_i,
  input  logic [TAG_BITS-1:0] issue_tag_i,
  input  logic [KindBits-1:0] kind_i,
  input  logic [DataBits-1:0] operand_a_i,
  input  logic [DataBits-1:0] operand_b_i,
  input  logic                retire_valid_i,
  input  logic [TAG_BITS-1:0] retire_tag_i,
  input  logic                squash_valid_i,
  input  logic [TAG_BITS-1:0] squash_tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                result_stored_o,
  output logic [DataBits-1:0] result_value_o,
  output logic [TAG_BITS-1:0] result_tag_o,
  output logic                result_is_address_o,
  output logic                result_is_control_o,
  output logic [TAG_BITS-1:0] oldest_tag_o,
  output logic [DataBits-1:0] oldest_value_o,
  output logic                oldest_is_address_o,
  output logic                oldest_is_control_o,
  output logic                buffer_empty_o,
  output logic                buffer_full_o
);

  localparam int unsigned IdxBits = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // input register
  logic                s1_valid_q;
  logic                s1_issue_q;
  logic [TAG_BITS-1:0] s1_tag_q;
  logic [KindBits-1:0] s1_kind_q;
  logic [DataBits-1:0] s1_a_q;
  logic [DataBits-1:0] s1_b_q;
  logic                s1_retire_q;
  logic [TAG_BITS-1:0] s1_retire_tag_q;
  logic                s1_squash_q;
  logic [TAG_BITS-1:0] s1_squash_tag_q;

  // buffer
  logic [BUFFER_DEPTH-1:0] entry_valid_q;
  logic [BUFFER_DEPTH-1:0] entry_valid_d;
  logic [TAG_BITS-1:0]     entry_tag_q   [BUFFER_DEPTH];
  alu_res_t                entry_res_q   [BUFFER_DEPTH];

  // result register
  logic                out_valid_q;
  logic                res_valid_q;
  alu_res_t            res_q;
  logic [TAG_BITS-1:0] res_tag_q;
  logic [TAG_BITS-1:0] old_tag_q;
  alu_res_t            old_res_q;
  logic                empty_q;
  logic                full_q;

  logic                    advance;
  logic                    empty;
  logic                    full;
  logic                    oldest_found;
  logic [IdxBits-1:0]      oldest_idx;
  logic [TAG_BITS-1:0]     oldest_tag;
  logic                    free_found;
  logic [IdxBits-1:0]      free_idx;
  logic [BUFFER_DEPTH-1:0] clear;
  logic                    result_ok;
  alu_res_t                alu_res;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  atrb_alu u_alu (
    .kind_i      (s1_kind_q),
    .operand_a_i (s1_a_q),
    .operand_b_i (s1_b_q),
    .res_o       (alu_res)
  );

  always_comb begin
    logic ret_found;
    empty        = 1'b1;
    full         = 1'b1;
    oldest_found = 1'b0;
    oldest_idx   = '0;
    oldest_tag   = '0;
    free_found   = 1'b0;
    free_idx     = '0;
    ret_found    = 1'b0;
    clear        = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      if (entry_valid_q[i]) begin
        empty = 1'b0;
        if (!oldest_found || entry_tag_q[i] < oldest_tag) begin
          oldest_found = 1'b1;
          oldest_idx   = IdxBits'(i);
          oldest_tag   = entry_tag_q[i];
        end
        if (s1_squash_q && entry_tag_q[i] > s1_squash_tag_q) begin
          clear[i] = 1'b1;
        end
        if (s1_retire_q && !ret_found && entry_tag_q[i] == s1_retire_tag_q) begin
          clear[i]  = 1'b1;
          ret_found = 1'b1;
        end
      end else begin
        full = 1'b0;
        if (!free_found) begin
          free_found = 1'b1;
          free_idx   = IdxBits'(i);
        end
      end
    end
  end

  assign result_ok = s1_issue_q && (!s1_squash_q || s1_tag_q < s1_squash_tag_q) && free_found;

  always_comb begin
    entry_valid_d = entry_valid_q;
    if (result_ok) begin
      entry_valid_d[free_idx] = 1'b1;
    end
    entry_valid_d = entry_valid_d & ~clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      entry_valid_q <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        entry_valid_q <= entry_valid_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_issue_q      <= issue_valid_i;
      s1_tag_q        <= issue_tag_i;
      s1_kind_q       <= kind_i;
      s1_a_q          <= operand_a_i;
      s1_b_q          <= operand_b_i;
      s1_retire_q     <= retire_valid_i;
      s1_retire_tag_q <= retire_tag_i;
      s1_squash_q     <= squash_valid_i;
      s1_squash_tag_q <= squash_tag_i;
    end
    if (advance) begin
      if (result_ok) begin
        entry_tag_q[free_idx] <= s1_tag_q;
        entry_res_q[free_idx] <= alu_res;
      end
      res_valid_q <= result_ok;
      res_q       <= result_ok ? alu_res : '0;
      res_tag_q   <= result_ok ? s1_tag_q : '0;
      old_tag_q   <= oldest_found ? oldest_tag : '0;
      old_res_q   <= oldest_found ? entry_res_q[oldest_idx] : '0;
      empty_q     <= empty;
      full_q      <= full;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_stored_o     = res_valid_q;
  assign result_value_o      = res_q.value;
  assign result_tag_o        = res_tag_q;
  assign result_is_address_o = res_q.is_address;
  assign result_is_control_o = res_q.is_control;
  assign oldest_tag_o        = old_tag_q;
  assign oldest_value_o      = old_res_q.value;
  assign oldest_is_address_o = old_res_q.is_address;
  assign oldest_is_control_o = old_res_q.is_control;
  assign buffer_empty_o      = empty_q;
  assign buffer_full_o       = full_q;

  `ATRB_NEVER(a_empty_and_full, out_valid_q && empty_q && full_q, "buffer both empty and full")
  `ATRB_NEVER(a_result_when_full, out_valid_q && res_valid_q && full_q, "result from full buffer")
  `ATRB_ASSERT(a_stored_result, advance && result_ok |=> entry_valid_q != '0, "result not stored")
  `ATRB_ASSERT(a_fill_step, $countones(entry_valid_q) <= $past($countones(entry_valid_q)) + 1, "buffer grew by more than one entry")

endmodule
